@@ rtl/vdt_pkg.sv @@
// Shared types, constants and codes for the voxel dose tally.
`timescale 1ns / 1ps

package vdt_pkg;

  localparam int MAX_VOXELS_X = 32;
  localparam int MAX_VOXELS_Y = 32;
  localparam int MAX_VOXELS_Z = 32;
  localparam int STORE_DEPTH  = MAX_VOXELS_X * MAX_VOXELS_Y * MAX_VOXELS_Z;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int SUM_W = 56;
  localparam int SQ_W  = 64;
  localparam int CNT_W = 32;
  localparam int E_W   = 24;
  localparam int IDX_W = 5;
  localparam int CFG_W = 6;

  // Square of 100 * 65536, the percent and Q16.16 scale of the deviation.
  localparam logic [45:0] RSD_SCALE_SQ = 46'd42949672960000;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_ZERO    = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_VOX_X = 2'd0,
    CFG_VOX_Y = 2'd1,
    CFG_VOX_Z = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_UPD,
    T_CALC,
    T_FIN
  } top_state_t;

  typedef enum logic [3:0] {
    RS_IDLE,
    RS_MUL_NQ,
    RS_MUL_SS,
    RS_SUB,
    RS_MUL_K,
    RS_DIV_N,
    RS_SQRT,
    RS_DIV_S,
    RS_DONE
  } rsd_state_t;

  typedef struct packed {
    logic             in_scoring_volume;
    logic [IDX_W-1:0] voxel_x;
    logic [IDX_W-1:0] voxel_y;
    logic [IDX_W-1:0] voxel_z;
    logic [E_W-1:0]   energy_ev;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [SUM_W-1:0] voxel_energy_sum;
    logic [CNT_W-1:0] voxel_hit_count;
    logic [CNT_W-1:0] voxel_rsd;
    logic [CNT_W-1:0] total_hits;
  } out_word_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } mem_entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] s;
    logic [SQ_W-1:0]  q;
    logic [CNT_W-1:0] n;
  } rsd_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rsd;
  } rsd_rsp_t;

endpackage

@@ rtl/voxel_dose_tally_with_rsd.sv @@
// Top level of the voxel dose tally with per-voxel relative standard deviation.
//
// Usage: each input word is one hit (scoring-volume flag, voxel x/y/z, energy in eV).
// Every accepted word yields exactly one output word with a status, the voxel's
// energy sum and hit count after the hit, the global hit count and the voxel's
// relative standard deviation in Q16.16 percent. Both channels use valid/stall; a
// word moves on a rising edge with valid high and stall low.
// One hit is processed at a time. A hit that is not counted passes from acceptance
// through T_FIN to the output register, and the next hit waits until it is loaded.
// A counted hit spends state T_UPD on the read-modify-write of the voxel entry and
// then waits in T_CALC for the deviation unit, which runs a bit-serial sequence of
// three shift-add multiplies (32, 56 and 46 steps), a 144-step divide, a 72-step
// square root and a 72-step divide. On the first hit on a voxel the unit goes straight
// to its done state, and a voxel whose variance is zero skips the later steps.
// A finished word sits in the output register; a new hit is accepted while it waits,
// and a later result waits in turn until the receiver stops stalling.
// After reset the block sweeps the voxel store to zero, one entry a cycle through all
// 32768 entries, and holds in_stall high meanwhile. Configuration writes (voxels in
// use per axis) are taken at any time, but belong to periods when the block is idle.
`timescale 1ns / 1ps

module voxel_dose_tally_with_rsd import vdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  top_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  vox_x_r, vox_y_r, vox_z_r;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  // Item held while it is being worked on.
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [E_W-1:0]    e_r, e_nxt;
  logic [2*E_W-1:0]  e2_r, e2_nxt;
  logic [SUM_W-1:0]  res_sum_r, res_sum_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [CNT_W-1:0]  res_rsd_r, res_rsd_nxt;

  // Voxel store: one word per voxel holding sum, sum of squares and count.
  mem_entry_t        mem [STORE_DEPTH];
  mem_entry_t        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  mem_entry_t        mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  status_t           in_status;
  logic              in_range_bad;
  logic [SUM_W:0]    sum_add;
  logic [SQ_W:0]     sq_add;
  logic [SUM_W-1:0]  sum_new;
  logic [SQ_W-1:0]   sq_new;
  logic [CNT_W-1:0]  cnt_new;
  logic              fin_load;

  rsd_req_t rsd_req;
  rsd_rsp_t rsd_rsp;

  vdt_rsd u_rsd (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rsd_req),
    .rsp  (rsd_rsp)
  );

  // An index is out of range if it is not below its register or the store size.
  assign in_range_bad = ({1'b0, in_data.voxel_x} >= vox_x_r) ||
                        (int'(in_data.voxel_x) >= MAX_VOXELS_X) ||
                        ({1'b0, in_data.voxel_y} >= vox_y_r) ||
                        (int'(in_data.voxel_y) >= MAX_VOXELS_Y) ||
                        ({1'b0, in_data.voxel_z} >= vox_z_r) ||
                        (int'(in_data.voxel_z) >= MAX_VOXELS_Z);

  always_comb begin
    if (!in_data.in_scoring_volume) begin
      in_status = ST_OUTSIDE;
    end else if (in_data.energy_ev == '0) begin
      in_status = ST_ZERO;
    end else if (in_range_bad) begin
      in_status = ST_RANGE;
    end else begin
      in_status = ST_COUNTED;
    end
  end

  assign rd_addr = ADDR_W'((int'(in_data.voxel_x) * MAX_VOXELS_Y + int'(in_data.voxel_y))
                           * MAX_VOXELS_Z + int'(in_data.voxel_z));

  // Saturating updates of the entry read for the held hit.
  assign sum_add = {1'b0, rd_data_r.sum} + {(SUM_W - E_W + 1)'(0), e_r};
  assign sq_add  = {1'b0, rd_data_r.sq} + {(SQ_W - 2*E_W + 1)'(0), e2_r};
  assign sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign sq_new  = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
  assign cnt_new = (rd_data_r.cnt == '1) ? rd_data_r.cnt : rd_data_r.cnt + 32'd1;

  assign in_stall  = state_r != T_IDLE;
  assign fin_load  = (state_r == T_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      vox_x_r     <= CFG_W'(MAX_VOXELS_X);
      vox_y_r     <= CFG_W'(MAX_VOXELS_Y);
      vox_z_r     <= CFG_W'(MAX_VOXELS_Z);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VOX_X: vox_x_r <= cfg_wdata;
          CFG_VOX_Y: vox_y_r <= cfg_wdata;
          CFG_VOX_Z: vox_z_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    e_r        <= e_nxt;
    e2_r       <= e2_nxt;
    res_sum_r  <= res_sum_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_rsd_r  <= res_rsd_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    e_nxt         = e_r;
    e2_nxt        = e2_r;
    res_sum_nxt   = res_sum_r;
    res_cnt_nxt   = res_cnt_r;
    res_rsd_nxt   = res_rsd_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '{sum: sum_new, sq: sq_new, cnt: cnt_new};
    rsd_req       = '{start: 1'b0, s: sum_new, q: sq_new, n: cnt_new};
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      T_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        if (in_valid) begin
          // The store read for this hit is issued at this same edge.
          status_nxt  = in_status;
          addr_nxt    = rd_addr;
          e_nxt       = in_data.energy_ev;
          e2_nxt      = (2*E_W)'(in_data.energy_ev) * (2*E_W)'(in_data.energy_ev);
          res_sum_nxt = '0;
          res_cnt_nxt = '0;
          res_rsd_nxt = '0;
          state_nxt   = (in_status == ST_COUNTED) ? T_UPD : T_FIN;
        end
      end
      T_UPD: begin
        mem_we        = 1'b1;
        rsd_req.start = 1'b1;
        res_sum_nxt   = sum_new;
        res_cnt_nxt   = cnt_new;
        total_nxt     = (total_r == '1) ? total_r : total_r + 32'd1;
        state_nxt     = T_CALC;
      end
      T_CALC: begin
        if (rsd_rsp.done) begin
          res_rsd_nxt = rsd_rsp.rsd;
          state_nxt   = T_FIN;
        end
      end
      T_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status:           status_r,
                            voxel_energy_sum: res_sum_r,
                            voxel_hit_count:  res_cnt_r,
                            voxel_rsd:        res_rsd_r,
                            total_hits:       total_r};
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // An accepted word always closes the input in the cycle after it.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A hit that was not counted reports an empty voxel.
  a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_COUNTED) |->
      (out_data.voxel_hit_count == '0 && out_data.voxel_energy_sum == '0 &&
       out_data.voxel_rsd == '0))
    else $error("uncounted hit reports voxel data");

  // A counted hit leaves at least one hit in its voxel and in the total.
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_COUNTED) |->
      (out_data.voxel_hit_count != '0 && out_data.total_hits != '0 &&
       out_data.voxel_energy_sum != '0))
    else $error("counted hit reports an empty voxel");

  // The deviation unit, started only from the update state, reports only in the calculation wait.
  a_rsd_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    rsd_rsp.done |-> state_r == T_CALC)
    else $error("deviation result outside the calculation wait");

endmodule

@@ rtl/vdt_rsd.sv @@
// Bit-serial relative standard deviation unit: shift-add multiply, restoring divide, root.
`timescale 1ns / 1ps

module vdt_rsd import vdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rsd_req_t req,
  output rsd_rsp_t rsp
);

  rsd_state_t state_r, state_nxt;

  logic [SUM_W-1:0] s_r, s_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [95:0]      p1_r, p1_nxt;
  logic [143:0]     acc_r, acc_nxt;
  logic [111:0]     mcand_r, mcand_nxt;
  logic [55:0]      mplier_r, mplier_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [143:0]     quo_r, quo_nxt;
  logic [55:0]      rem_r, rem_nxt;
  logic [55:0]      dvsr_r, dvsr_nxt;
  logic [71:0]      root_r, root_nxt;
  logic [73:0]      srem_r, srem_nxt;
  logic [CNT_W-1:0] rsd_r, rsd_nxt;

  logic [143:0] mul_sum;
  logic [56:0]  div_trial;
  logic [56:0]  div_diff;
  logic         div_ge;
  logic [143:0] div_quo;
  logic [75:0]  sq_cur;
  logic [75:0]  sq_trial;
  logic         sq_ge;
  logic [75:0]  sq_diff;
  logic [71:0]  sq_root;
  logic         last;

  // One step of each serial unit; the sequencer picks which result it keeps.
  assign mul_sum   = {acc_r[142:0], 1'b0} + (mplier_r[55] ? {32'd0, mcand_r} : 144'd0);
  assign div_trial = {rem_r, quo_r[143]};
  assign div_ge    = div_trial >= {1'b0, dvsr_r};
  assign div_diff  = div_trial - {1'b0, dvsr_r};
  assign div_quo   = {quo_r[142:0], div_ge};
  assign sq_cur    = {srem_r, quo_r[143:142]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = sq_cur >= sq_trial;
  assign sq_diff   = sq_cur - sq_trial;
  assign sq_root   = {root_r[70:0], sq_ge};
  assign last      = cnt_r == 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    n_r      <= n_nxt;
    p1_r     <= p1_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    rsd_r    <= rsd_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    n_nxt      = n_r;
    p1_nxt     = p1_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvsr_nxt   = dvsr_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    rsd_nxt    = rsd_r;
    rsp.done   = 1'b0;
    rsp.rsd    = rsd_r;

    case (state_r)
      RS_IDLE: begin
        if (req.start) begin
          s_nxt = req.s;
          n_nxt = req.n;
          if (req.n <= 32'd1 || req.s == '0) begin
            rsd_nxt   = '0;
            state_nxt = RS_DONE;
          end else begin
            mcand_nxt  = {48'd0, req.q};
            mplier_nxt = {req.n, 24'd0};
            acc_nxt    = '0;
            cnt_nxt    = 8'd32;
            state_nxt  = RS_MUL_NQ;
          end
        end
      end
      RS_MUL_NQ: begin
        acc_nxt    = mul_sum;
        mplier_nxt = {mplier_r[54:0], 1'b0};
        cnt_nxt    = cnt_r - 8'd1;
        if (last) begin
          p1_nxt     = mul_sum[95:0];
          mcand_nxt  = {56'd0, s_r};
          mplier_nxt = s_r;
          acc_nxt    = '0;
          cnt_nxt    = 8'd56;
          state_nxt  = RS_MUL_SS;
        end
      end
      RS_MUL_SS: begin
        acc_nxt    = mul_sum;
        mplier_nxt = {mplier_r[54:0], 1'b0};
        cnt_nxt    = cnt_r - 8'd1;
        if (last) begin
          state_nxt = RS_SUB;
        end
      end
      RS_SUB: begin
        // A variance of zero or below gives a deviation of zero.
        if ({48'd0, p1_r} <= acc_r) begin
          rsd_nxt   = '0;
          state_nxt = RS_DONE;
        end else begin
          mcand_nxt  = {16'd0, p1_r} - acc_r[111:0];
          mplier_nxt = {RSD_SCALE_SQ, 10'd0};
          acc_nxt    = '0;
          cnt_nxt    = 8'd46;
          state_nxt  = RS_MUL_K;
        end
      end
      RS_MUL_K: begin
        acc_nxt    = mul_sum;
        mplier_nxt = {mplier_r[54:0], 1'b0};
        cnt_nxt    = cnt_r - 8'd1;
        if (last) begin
          quo_nxt   = mul_sum;
          rem_nxt   = '0;
          dvsr_nxt  = {24'd0, n_r - 32'd1};
          cnt_nxt   = 8'd144;
          state_nxt = RS_DIV_N;
        end
      end
      RS_DIV_N: begin
        quo_nxt = div_quo;
        rem_nxt = div_ge ? div_diff[55:0] : div_trial[55:0];
        cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = 8'd72;
          state_nxt = RS_SQRT;
        end
      end
      RS_SQRT: begin
        quo_nxt  = {quo_r[141:0], 2'b00};
        srem_nxt = sq_ge ? sq_diff[73:0] : sq_cur[73:0];
        root_nxt = sq_root;
        cnt_nxt  = cnt_r - 8'd1;
        if (last) begin
          quo_nxt   = {sq_root, 72'd0};
          rem_nxt   = '0;
          dvsr_nxt  = s_r;
          cnt_nxt   = 8'd72;
          state_nxt = RS_DIV_S;
        end
      end
      RS_DIV_S: begin
        quo_nxt = div_quo;
        rem_nxt = div_ge ? div_diff[55:0] : div_trial[55:0];
        cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          rsd_nxt   = (div_quo[71:32] != '0) ? '1 : div_quo[31:0];
          state_nxt = RS_DONE;
        end
      end
      RS_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = RS_IDLE;
      end
      default: begin
        state_nxt = RS_IDLE;
      end
    endcase
  end

endmodule
